@@ hw/rtl/linear_blend_skinning_vertex_top_assert.svh @@
// Assertion macros for the skinning block's checker.
`ifndef LINEAR_BLEND_SKINNING_VERTEX_TOP_ASSERT_SVH
`define LINEAR_BLEND_SKINNING_VERTEX_TOP_ASSERT_SVH

// Implication checked on the same edge, quiet during reset.
`define LBS_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("skinning block check failed");

// Implication checked on the next edge, quiet during reset.
`define LBS_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("skinning block check failed");

// Implication checked on the next edge, also while reset is high.
`define LBS_ASSERT_ALWAYS(label, cond, prop) \
  label: assert property (@(posedge clk) (cond) |=> (prop)) \
    else $error("skinning block check failed");

`endif

@@ hw/rtl/lbs_pkg.sv @@
// Types, constants and helpers shared by the skinning block.
package lbs_pkg;

  localparam int JOINT_BITS = 6;
  localparam int DOT_W      = 34;
  localparam int WT_W       = 51;
  localparam int ACC_W      = 53;
  localparam int FRAC_SHIFT = 27;
  localparam int Q_W        = ACC_W - FRAC_SHIFT;

  typedef enum logic [1:0] {
    MODE_POSE   = 2'd0,
    MODE_NORMAL = 2'd1,
    MODE_SKIN   = 2'd2
  } mode_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [5:0]         joint_slot;
    logic [1:0]         row_slot;
    logic [63:0]        row_data;
    logic [47:0]        position;
    logic [47:0]        normal;
    logic [47:0]        tangent;
    logic signed [15:0] tangent_w;
    logic [23:0]        joint_indices;
    logic [63:0]        weights;
  } item_t;

  typedef struct packed {
    logic [47:0]        skinned_position;
    logic [47:0]        skinned_normal;
    logic [47:0]        skinned_tangent;
    logic signed [15:0] skinned_tangent_w;
  } result_t;

  // Stage load strobes handed from the top level to each influence lane.
  typedef struct packed {
    logic ld_a;
    logic ld_b;
    logic ld_c;
    logic ld_d;
  } adv_t;

  // Matrix row write request.
  typedef struct packed {
    logic                  pose_we;
    logic                  nrm_we;
    logic [1:0]            row;
    logic [JOINT_BITS-1:0] joint;
    logic [63:0]           data;
  } wr_t;

  typedef logic signed [WT_W-1:0]  wterm_t;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef wterm_t [2:0]            wvec_t;

  localparam acc_t ROUND_HALF = acc_t'(1) <<< (FRAC_SHIFT - 1);

  // Sign-extend one weighted term to accumulator width.
  function automatic acc_t ext(input wterm_t x);
    return {{(ACC_W-WT_W){x[WT_W-1]}}, x};
  endfunction

  // Round to nearest Q7.8 (ties up) and saturate to 16 bits.
  function automatic logic [15:0] round_sat(input acc_t acc);
    acc_t                 t;
    logic signed [Q_W-1:0] q;
    t = acc + ROUND_HALF;
    q = t[ACC_W-1:FRAC_SHIFT];
    priority if (q > $signed(Q_W'(32767))) return 16'h7fff;
    else if (q < -$signed(Q_W'(32768))) return 16'h8000;
    else return q[15:0];
  endfunction

endpackage

@@ hw/rtl/lbs_ram.sv @@
// Simple dual-port RAM with one write port and one registered read port.
module lbs_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 64
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/lbs_lane.sv @@
// One influence lane: matrix row copies, row products, dot sums and weighting.
module lbs_lane #(
  parameter int MAX_JOINTS = 64
) (
  input  logic                             clk,
  input  lbs_pkg::adv_t                    adv,
  input  lbs_pkg::wr_t                     wr,
  input  logic [lbs_pkg::JOINT_BITS-1:0]   joint,
  input  logic [15:0]                      weight,
  input  logic [47:0]                      pos,
  input  logic [47:0]                      nrm,
  input  logic [47:0]                      tan,
  output lbs_pkg::wvec_t                   wpos,
  output lbs_pkg::wvec_t                   wnrm,
  output lbs_pkg::wvec_t                   wtan
);
  import lbs_pkg::*;

  localparam int JW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

  logic [63:0] prow [4];
  logic [63:0] nrow [3];
  logic        in_range;

  logic [15:0] w_a, w_b, w_c;
  logic        skip_a, skip_b, skip_c;

  logic signed [31:0] pp_p [3][3];
  logic signed [31:0] pp_n [3][3];
  logic signed [31:0] pp_t [3][3];
  logic signed [15:0] r3_b [3];

  logic signed [DOT_W-1:0] dp_c [3];
  logic signed [DOT_W-1:0] dn_c [3];
  logic signed [DOT_W-1:0] dt_c [3];

  assign in_range = {1'b0, joint} < (JOINT_BITS+1)'(MAX_JOINTS);

  // Per-lane copies of the pose rows (all four) and normal rows (w is zero,
  // so the last normal row is never read and is not kept).
  for (genvar r = 0; r < 4; r++) begin : g_pose
    lbs_ram #(.DEPTH(MAX_JOINTS), .AW(JW), .DW(64)) u_ram (
      .clk   (clk),
      .we    (wr.pose_we && (wr.row == 2'(r))),
      .waddr (wr.joint[JW-1:0]),
      .wdata (wr.data),
      .re    (adv.ld_a),
      .raddr (joint[JW-1:0]),
      .rdata (prow[r])
    );
  end

  for (genvar r = 0; r < 3; r++) begin : g_nrm
    lbs_ram #(.DEPTH(MAX_JOINTS), .AW(JW), .DW(64)) u_ram (
      .clk   (clk),
      .we    (wr.nrm_we && (wr.row == 2'(r))),
      .waddr (wr.joint[JW-1:0]),
      .wdata (wr.data),
      .re    (adv.ld_a),
      .raddr (joint[JW-1:0]),
      .rdata (nrow[r])
    );
  end

  // Stage A: weight and skip flag travel beside the RAM read.
  always_ff @(posedge clk) begin
    if (adv.ld_a) begin
      w_a    <= weight;
      skip_a <= !in_range || (weight == 16'd0);
    end
  end

  // Stage B: element products of rows 0 to 2 for every column; row 3 is copied.
  always_ff @(posedge clk) begin
    if (adv.ld_b) begin
      w_b    <= w_a;
      skip_b <= skip_a;
      for (int c = 0; c < 3; c++) begin
        r3_b[c] <= $signed(prow[3][16*c +: 16]);
        for (int r = 0; r < 3; r++) begin
          pp_p[c][r] <= $signed(pos[16*r +: 16]) * $signed(prow[r][16*c +: 16]);
          pp_t[c][r] <= $signed(tan[16*r +: 16]) * $signed(prow[r][16*c +: 16]);
          pp_n[c][r] <= $signed(nrm[16*r +: 16]) * $signed(nrow[r][16*c +: 16]);
        end
      end
    end
  end

  // Stage C: dot sums; the position's w of one adds row three shifted by 8.
  always_ff @(posedge clk) begin
    if (adv.ld_c) begin
      w_c    <= w_b;
      skip_c <= skip_b;
      for (int c = 0; c < 3; c++) begin
        dp_c[c] <= DOT_W'(pp_p[c][0]) + DOT_W'(pp_p[c][1]) + DOT_W'(pp_p[c][2])
                 + {{(DOT_W-24){r3_b[c][15]}}, r3_b[c], 8'd0};
        dn_c[c] <= DOT_W'(pp_n[c][0]) + DOT_W'(pp_n[c][1]) + DOT_W'(pp_n[c][2]);
        dt_c[c] <= DOT_W'(pp_t[c][0]) + DOT_W'(pp_t[c][1]) + DOT_W'(pp_t[c][2]);
      end
    end
  end

  // Stage D: scale by the weight; skipped influences give zero.
  always_ff @(posedge clk) begin
    if (adv.ld_d) begin
      for (int c = 0; c < 3; c++) begin
        wpos[c] <= skip_c ? '0 : WT_W'(dp_c[c]) * $signed({1'b0, w_c});
        wnrm[c] <= skip_c ? '0 : WT_W'(dn_c[c]) * $signed({1'b0, w_c});
        wtan[c] <= skip_c ? '0 : WT_W'(dt_c[c]) * $signed({1'b0, w_c});
      end
    end
  end

endmodule

@@ hw/rtl/linear_blend_skinning_vertex_top.sv @@
// Linear blend skinning block: one vertex word per clock, fully pipelined.
// A load word (pose or normal row) is written into the row RAMs on acceptance;
// each of the four influence lanes holds its own copy of the pose rows and the
// first three normal rows, so all sixteen pose and twelve normal rows of a
// vertex are read in the same cycle. Skin words pass registered stages for RAM
// read, products, dot sums, weighting, influence sum, and round and saturate
// to result_valid; one word can enter every cycle while no stall backs up. A
// load word written on one edge is seen by a skin word accepted on the next.
module linear_blend_skinning_vertex_top #(
  parameter int MAX_JOINTS = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  lbs_pkg::item_t  item,
  output logic            result_valid,
  input  logic            result_stall,
  output lbs_pkg::result_t result
);
  import lbs_pkg::*;

  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_f;
  logic v_a, v_b, v_c, v_d, v_e;
  logic accepted, load_ok;
  adv_t adv;
  wr_t  wr;

  logic [47:0]        pos_a, nrm_a, tan_a;
  logic signed [15:0] tw_a, tw_b, tw_c, tw_d, tw_e;

  wvec_t wpos_l [4];
  wvec_t wnrm_l [4];
  wvec_t wtan_l [4];

  acc_t ap_e [3];
  acc_t an_e [3];
  acc_t at_e [3];

  // Ready chain: a stage loads when it is empty or its successor moves.
  assign rdy_f = !result_valid || !result_stall;
  assign rdy_e = !v_e || rdy_f;
  assign rdy_d = !v_d || rdy_e;
  assign rdy_c = !v_c || rdy_d;
  assign rdy_b = !v_b || rdy_c;
  assign rdy_a = !v_a || rdy_b;
  assign item_stall = !rdy_a;

  assign adv = '{ld_a: rdy_a, ld_b: rdy_b, ld_c: rdy_c, ld_d: rdy_d};

  // Row writes for load words whose joint is in range.
  assign accepted = item_valid && !item_stall;
  assign load_ok  = {1'b0, item.joint_slot} < (JOINT_BITS+1)'(MAX_JOINTS);
  assign wr.pose_we = accepted && load_ok && (item.mode == MODE_POSE);
  assign wr.nrm_we  = accepted && load_ok && (item.mode == MODE_NORMAL);
  assign wr.row     = item.row_slot;
  assign wr.joint   = item.joint_slot;
  assign wr.data    = item.row_data;

  // Valid bits: only skin words produce a result.
  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
      v_d <= 1'b0;
      v_e <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (rdy_a) v_a <= item_valid && (item.mode == MODE_SKIN);
      if (rdy_b) v_b <= v_a;
      if (rdy_c) v_c <= v_b;
      if (rdy_d) v_d <= v_c;
      if (rdy_e) v_e <= v_d;
      if (rdy_f) result_valid <= v_e;
    end
  end

  // Stage A vertex registers and the tangent w delay line.
  always_ff @(posedge clk) begin
    if (rdy_a) begin
      pos_a <= item.position;
      nrm_a <= item.normal;
      tan_a <= item.tangent;
      tw_a  <= item.tangent_w;
    end
    if (rdy_b) tw_b <= tw_a;
    if (rdy_c) tw_c <= tw_b;
    if (rdy_d) tw_d <= tw_c;
    if (rdy_e) tw_e <= tw_d;
  end

  // Four influence lanes.
  for (genvar k = 0; k < 4; k++) begin : g_lane
    lbs_lane #(.MAX_JOINTS(MAX_JOINTS)) u_lane (
      .clk    (clk),
      .adv    (adv),
      .wr     (wr),
      .joint  (item.joint_indices[6*k +: 6]),
      .weight (item.weights[16*k +: 16]),
      .pos    (pos_a),
      .nrm    (nrm_a),
      .tan    (tan_a),
      .wpos   (wpos_l[k]),
      .wnrm   (wnrm_l[k]),
      .wtan   (wtan_l[k])
    );
  end

  // Stage E: sum the four influences.
  always_ff @(posedge clk) begin
    if (rdy_e) begin
      for (int c = 0; c < 3; c++) begin
        ap_e[c] <= ext(wpos_l[0][c]) + ext(wpos_l[1][c])
                 + ext(wpos_l[2][c]) + ext(wpos_l[3][c]);
        an_e[c] <= ext(wnrm_l[0][c]) + ext(wnrm_l[1][c])
                 + ext(wnrm_l[2][c]) + ext(wnrm_l[3][c]);
        at_e[c] <= ext(wtan_l[0][c]) + ext(wtan_l[1][c])
                 + ext(wtan_l[2][c]) + ext(wtan_l[3][c]);
      end
    end
  end

  // Stage F: round, saturate and hold the result word.
  always_ff @(posedge clk) begin
    if (rdy_f) begin
      for (int c = 0; c < 3; c++) begin
        result.skinned_position[16*c +: 16] <= round_sat(ap_e[c]);
        result.skinned_normal[16*c +: 16]   <= round_sat(an_e[c]);
        result.skinned_tangent[16*c +: 16]  <= round_sat(at_e[c]);
      end
      result.skinned_tangent_w <= tw_e;
    end
  end

endmodule

@@ hw/rtl/lbs_check.sv @@
// Port-level checker for the skinning block and its bind.
`include "linear_blend_skinning_vertex_top_assert.svh"

module lbs_check (
  input logic             clk,
  input logic             rst,
  input logic             item_stall,
  input logic             result_valid,
  input logic             result_stall,
  input lbs_pkg::result_t result
);
  import lbs_pkg::*;

  // A stalled result word stays put.
  `LBS_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))

  // With the output register empty every stage can move, so input never stalls.
  `LBS_ASSERT_NOW(a_no_false_stall, !result_valid, !item_stall)

  // Reset empties the pipeline.
  `LBS_ASSERT_ALWAYS(a_reset_empty, rst, !result_valid)

endmodule

bind linear_blend_skinning_vertex_top lbs_check u_lbs_check (.*);
